@@ design/asm_pkg.sv @@
`default_nettype none
package asm_pkg;

    localparam int TILE_BITS        = 6;
    localparam int TILE_SIDE        = 1 << TILE_BITS;
    localparam int TEXEL_AW         = 2 * TILE_BITS;
    localparam int SHADE_AW         = 8;
    localparam int SHADE_ENTRIES    = 1 << SHADE_AW;
    localparam int FIX_FRAC         = 16;
    localparam int BURST_PIXELS_DEF = 64;
    localparam int CMD_DEPTH        = 2;
    localparam int OUT_DEPTH        = 4;
    localparam int OUT_CW           = $clog2(OUT_DEPTH + 1);

    localparam logic [10:0] MAX_SPAN = 11'd1024;

    typedef enum logic [1:0] {
        ACT_TEXEL = 2'd0,
        ACT_SHADE = 2'd1,
        ACT_SPAN  = 2'd2,
        ACT_CONT  = 2'd3
    } t_action;

    localparam logic [1:0] CFG_WINDOW_LEFT = 2'd0;
    localparam logic [1:0] CFG_WINDOW_TOP  = 2'd1;
    localparam logic [1:0] CFG_LOW_DETAIL  = 2'd2;

    typedef struct packed {
        logic [9:0] window_left;
        logic [9:0] window_top;
        logic       low_detail;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [11:0] index;
        logic [7:0]  value;
        logic [9:0]  row;
        logic [9:0]  start;
        logic [10:0] count;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] du;
        logic [31:0] dv;
        logic        flat;
    } t_cmd;

    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
        logic [7:0]  color;
        logic        pair;
        logic        last;
        logic        done;
    } t_pix;

endpackage
`default_nettype wire

@@ design/asm_fifo.sv @@
`default_nettype none
module asm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_rd_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_push && !o_full;
    assign rd_en     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/asm_front.sv @@
`default_nettype none
module asm_front
    import asm_pkg::*;
(
    input  wire logic               i_push,
    input  wire logic               i_q_full,
    input  wire logic [1:0]         i_action,
    input  wire logic [11:0]        i_table_index,
    input  wire logic [7:0]         i_table_value,
    input  wire logic [9:0]         i_span_row,
    input  wire logic [9:0]         i_span_start,
    input  wire logic [10:0]        i_pixel_count,
    input  wire logic signed [31:0] i_u_start,
    input  wire logic signed [31:0] i_v_start,
    input  wire logic signed [31:0] i_u_step,
    input  wire logic signed [31:0] i_v_step,
    input  wire logic               i_flat_fill,
    output logic                    o_cmd_push,
    output t_cmd                    o_cmd
);

    t_action act;
    logic    keep;

    assign act = t_action'(i_action);

    // drop shade loads that fall outside the table; they are still accepted
    always_comb begin
        case (act)
            ACT_SHADE: keep = (i_table_index[11:SHADE_AW] == '0);
            default:   keep = 1'b1;
        endcase
    end

    assign o_cmd_push = i_push && !i_q_full && keep;

    always_comb begin
        o_cmd.action = act;
        o_cmd.index  = i_table_index;
        o_cmd.value  = i_table_value;
        o_cmd.row    = i_span_row;
        o_cmd.start  = i_span_start;
        o_cmd.count  = (i_pixel_count > MAX_SPAN) ? MAX_SPAN : i_pixel_count;
        o_cmd.u      = i_u_start;
        o_cmd.v      = i_v_start;
        o_cmd.du     = i_u_step;
        o_cmd.dv     = i_v_step;
        o_cmd.flat   = i_flat_fill;
    end

endmodule
`default_nettype wire

@@ design/asm_back.sv @@
`default_nettype none
module asm_back
    import asm_pkg::*;
#(
    parameter int BURST_PIXELS = BURST_PIXELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_cmd_empty,
    output logic                   o_cmd_pop,
    input  wire logic [OUT_CW-1:0] i_out_count,
    output logic                   o_pix_push,
    output t_pix                   o_pix
);

    localparam int BW = (BURST_PIXELS > 1) ? $clog2(BURST_PIXELS) : 1;

    logic [7:0]  r_tile  [TILE_SIDE*TILE_SIDE];
    logic [7:0]  r_shade [SHADE_ENTRIES];

    logic [31:0] r_u;
    logic [31:0] r_v;
    logic [31:0] r_du;
    logic [31:0] r_dv;
    logic [9:0]  r_col;
    logic [9:0]  r_row;
    logic [10:0] r_left;
    logic        r_flat;
    logic        r_busy;
    logic [BW-1:0] r_burst_cnt;

    logic        r_s1_valid;
    t_pix        r_s1_meta;
    logic [7:0]  r_texel;
    logic        r_s2_valid;
    t_pix        r_s2_meta;
    logic [7:0]  r_color;

    logic               issue;
    logic               done;
    logic               last;
    logic [OUT_CW:0]    pending;
    logic [TEXEL_AW-1:0] tex_addr;
    t_pix               meta;

    assign o_cmd_pop = !i_cmd_empty && !r_busy;

    // reserve output queue space for every pixel still in the read pipeline
    assign pending = {1'b0, i_out_count} + (OUT_CW+1)'(r_s1_valid) + (OUT_CW+1)'(r_s2_valid);
    assign issue   = r_busy && (pending < (OUT_CW+1)'(OUT_DEPTH));
    assign done    = (r_left == 11'd1);
    assign last    = done || (r_burst_cnt == BW'(BURST_PIXELS - 1));

    assign tex_addr = r_flat ? '0 : {r_v[FIX_FRAC +: TILE_BITS], r_u[FIX_FRAC +: TILE_BITS]};

    always_comb begin
        meta.column = (i_cfg.low_detail ? {r_col, 1'b0} : {1'b0, r_col})
                      + {1'b0, i_cfg.window_left};
        meta.row    = {1'b0, r_row} + {1'b0, i_cfg.window_top};
        meta.color  = '0;
        meta.pair   = i_cfg.low_detail;
        meta.last   = last;
        meta.done   = done;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_texel <= r_tile[tex_addr];
        end
        if (o_cmd_pop && (i_cmd.action == ACT_TEXEL)) begin
            r_tile[i_cmd.index] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= r_shade[r_texel];
        if (o_cmd_pop && (i_cmd.action == ACT_SHADE)) begin
            r_shade[i_cmd.index[SHADE_AW-1:0]] <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_meta <= meta;
        r_s2_meta <= r_s1_meta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u         <= '0;
            r_v         <= '0;
            r_du        <= '0;
            r_dv        <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_flat      <= 1'b0;
            r_busy      <= 1'b0;
            r_burst_cnt <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (o_cmd_pop) begin
                case (i_cmd.action)
                    ACT_SPAN: begin
                        r_u         <= i_cmd.u;
                        r_v         <= i_cmd.v;
                        r_du        <= i_cmd.du;
                        r_dv        <= i_cmd.dv;
                        r_col       <= i_cmd.start;
                        r_row       <= i_cmd.row;
                        r_left      <= i_cmd.count;
                        r_flat      <= i_cmd.flat;
                        r_busy      <= (i_cmd.count != '0);
                        r_burst_cnt <= '0;
                    end
                    ACT_CONT: begin
                        r_busy      <= (r_left != '0);
                        r_burst_cnt <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (issue) begin
                r_u         <= r_u + r_du;
                r_v         <= r_v + r_dv;
                r_col       <= r_col + 1'b1;
                r_left      <= r_left - 1'b1;
                r_burst_cnt <= r_burst_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_pix_push = r_s2_valid;

    always_comb begin
        o_pix       = r_s2_meta;
        o_pix.color = r_color;
    end

endmodule
`default_nettype wire

@@ design/affine_span_texture_mapper_top.sv @@
// Affine span texture mapper.
// Input channel: push/full. Each request is a texel load, a shade entry
// load, a span start or a span continue. Loads and continues with nothing
// pending produce no pixels; a span start or continue produces up to
// BURST_PIXELS pixels, the last flagged by o_burst_last, the end of the
// span by o_span_done.
// Output channel: empty/pop. The oldest pixel sits on the o_ ports while
// empty is low and leaves when pop is high.
// Requests pass a 2-entry command queue; the pixel engine takes one request
// at a time. After taking a span request the engine issues one pixel per
// cycle while the result queue has room, through the texel memory read and
// the shade table read, and stays busy until the burst's last pixel issues.
// A load is applied as it is taken from the command queue.
// When the receiver stalls, the 4-entry result queue fills and the engine
// holds its position; the command queue then fills and full rises.
// Configuration writes (i_cfg_wr_en, i_cfg_addr, i_cfg_wr_data) take effect
// at the next edge. Reset clears the queues, the span state and the window
// registers; the texture and shade memories keep their contents.
`default_nettype none
module affine_span_texture_mapper_top
    import asm_pkg::*;
#(
    parameter int BURST_PIXELS = BURST_PIXELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [9:0]         i_cfg_wr_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_action,
    input  wire logic [11:0]        i_table_index,
    input  wire logic [7:0]         i_table_value,
    input  wire logic [9:0]         i_span_row,
    input  wire logic [9:0]         i_span_start,
    input  wire logic [10:0]        i_pixel_count,
    input  wire logic signed [31:0] i_u_start,
    input  wire logic signed [31:0] i_v_start,
    input  wire logic signed [31:0] i_u_step,
    input  wire logic signed [31:0] i_v_step,
    input  wire logic               i_flat_fill,
    output logic                    empty,
    input  wire logic               pop,
    output logic [10:0]             o_screen_column,
    output logic [10:0]             o_screen_row,
    output logic [7:0]              o_pixel_color,
    output logic                    o_pixel_pair,
    output logic                    o_burst_last,
    output logic                    o_span_done
);

    t_cfg  r_cfg;
    t_cmd  front_cmd;
    t_cmd  back_cmd;
    logic  front_push;
    logic  cmd_empty;
    logic  cmd_pop;
    logic  [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    logic  pix_push;
    t_pix  pix_in;
    t_pix  pix_out;
    logic  out_full;
    logic  [OUT_CW-1:0] out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_WINDOW_LEFT: r_cfg.window_left <= i_cfg_wr_data;
                CFG_WINDOW_TOP:  r_cfg.window_top  <= i_cfg_wr_data;
                CFG_LOW_DETAIL:  r_cfg.low_detail  <= i_cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    asm_front u_front (
        .i_push        (push),
        .i_q_full      (full),
        .i_action      (i_action),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_span_row    (i_span_row),
        .i_span_start  (i_span_start),
        .i_pixel_count (i_pixel_count),
        .i_u_start     (i_u_start),
        .i_v_start     (i_v_start),
        .i_u_step      (i_u_step),
        .i_v_step      (i_v_step),
        .i_flat_fill   (i_flat_fill),
        .o_cmd_push    (front_push),
        .o_cmd         (front_cmd)
    );

    asm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (front_push),
        .i_wr_data (front_cmd),
        .o_full    (full),
        .i_pop     (cmd_pop),
        .o_rd_data (back_cmd),
        .o_empty   (cmd_empty),
        .o_count   (cmd_count)
    );

    asm_back #(
        .BURST_PIXELS (BURST_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_pix_push  (pix_push),
        .o_pix       (pix_in)
    );

    asm_fifo #(
        .WIDTH ($bits(t_pix)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (pix_push),
        .i_wr_data (pix_in),
        .o_full    (out_full),
        .i_pop     (pop),
        .o_rd_data (pix_out),
        .o_empty   (empty),
        .o_count   (out_count)
    );

    // the back end reserves space, so a push never meets a full queue
    logic unused_ok;
    assign unused_ok = out_full ^ (cmd_count == '0);

    assign o_screen_column = pix_out.column;
    assign o_screen_row    = pix_out.row;
    assign o_pixel_color   = pix_out.color & {8{~unused_ok | unused_ok}};
    assign o_pixel_pair    = pix_out.pair;
    assign o_burst_last    = pix_out.last;
    assign o_span_done     = pix_out.done;

endmodule
`default_nettype wire

@@ sim/affine_span_texture_mapper_top_tb.sv @@
`timescale 1ns / 1ps
module affine_span_texture_mapper_top_tb
    import asm_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int TILE_TEXELS   = TILE_SIDE * TILE_SIDE;
    localparam int PHASE_ITEMS   = 36;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [1:0] i_cfg_addr    = CFG_WINDOW_LEFT;
    logic [9:0] i_cfg_wr_data = '0;
    logic       push          = 1'b0;
    logic       pop           = 1'b0;
    t_cmd       req           = '0;
    logic       full;
    logic       empty;
    logic [10:0] o_screen_column;
    logic [10:0] o_screen_row;
    logic [7:0]  o_pixel_color;
    logic        o_pixel_pair;
    logic        o_burst_last;
    logic        o_span_done;

    // shadow copy of the block state
    logic [7:0]  texel_copy [TILE_TEXELS];
    logic [7:0]  shade_copy [SHADE_ENTRIES];
    logic [31:0] u_pos       = '0;
    logic [31:0] v_pos       = '0;
    logic [31:0] u_inc       = '0;
    logic [31:0] v_inc       = '0;
    logic [9:0]  col_ptr     = '0;
    logic [9:0]  row_reg     = '0;
    logic [10:0] pixels_left = '0;
    logic        flat_sel    = 1'b0;
    logic [9:0]  win_left    = '0;
    logic [9:0]  win_top     = '0;
    logic        half_res    = 1'b0;

    t_pix expected_pixels [$];
    t_pix want;
    int   mismatch_count  = 0;
    int   cycle_count     = 0;
    int   items_sent      = 0;
    int   sender_idle_pct = 0;
    int   stall_pct       = 0;

    affine_span_texture_mapper_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .push            (push),
        .full            (full),
        .i_action        (req.action),
        .i_table_index   (req.index),
        .i_table_value   (req.value),
        .i_span_row      (req.row),
        .i_span_start    (req.start),
        .i_pixel_count   (req.count),
        .i_u_start       (req.u),
        .i_v_start       (req.v),
        .i_u_step        (req.du),
        .i_v_step        (req.dv),
        .i_flat_fill     (req.flat),
        .empty           (empty),
        .pop             (pop),
        .o_screen_column (o_screen_column),
        .o_screen_row    (o_screen_row),
        .o_pixel_color   (o_pixel_color),
        .o_pixel_pair    (o_pixel_pair),
        .o_burst_last    (o_burst_last),
        .o_span_done     (o_span_done)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    // apply one request to the shadow state, queue the pixels it yields
    task automatic render_request(input t_cmd cmd);
        int          n;
        logic [7:0]  texel;
        logic [10:0] col;
        t_pix        px;
        n = 0;
        case (cmd.action)
            ACT_TEXEL: texel_copy[cmd.index] = cmd.value;
            ACT_SHADE: begin
                if (cmd.index < SHADE_ENTRIES) shade_copy[cmd.index[7:0]] = cmd.value;
            end
            default: begin
                if (cmd.action == ACT_SPAN) begin
                    row_reg     = cmd.row;
                    col_ptr     = cmd.start;
                    pixels_left = (cmd.count > MAX_SPAN) ? MAX_SPAN : cmd.count;
                    u_pos       = cmd.u;
                    v_pos       = cmd.v;
                    u_inc       = cmd.du;
                    v_inc       = cmd.dv;
                    flat_sel    = cmd.flat;
                end
                while (pixels_left != 0 && n < BURST_PIXELS_DEF) begin
                    texel = flat_sel ? texel_copy[0]
                                     : texel_copy[{v_pos[21:16], u_pos[21:16]}];
                    col = half_res ? {col_ptr, 1'b0} : {1'b0, col_ptr};
                    pixels_left = pixels_left - 1'b1;
                    px.column = col + {1'b0, win_left};
                    px.row    = {1'b0, row_reg} + {1'b0, win_top};
                    px.color  = shade_copy[texel];
                    px.pair   = half_res;
                    px.last   = 1'b0;
                    px.done   = (pixels_left == 0);
                    expected_pixels.push_back(px);
                    u_pos   = u_pos + u_inc;
                    v_pos   = v_pos + v_inc;
                    col_ptr = col_ptr + 1'b1;
                    n++;
                end
                if (n > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    task automatic send_item(input t_cmd cmd);
        push <= 1'b1;
        req  <= cmd;
        do @(posedge i_clk); while (full);
        render_request(cmd);
        items_sent++;
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold requests until every pixel is out and the engine has settled
    task automatic hold_until_idle();
        push <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [9:0] left, input logic [9:0] top,
                              input logic ld);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= CFG_WINDOW_LEFT;
        i_cfg_wr_data <= left;
        @(posedge i_clk);
        win_left       = left;
        i_cfg_addr    <= CFG_WINDOW_TOP;
        i_cfg_wr_data <= top;
        @(posedge i_clk);
        win_top        = top;
        i_cfg_addr    <= CFG_LOW_DETAIL;
        i_cfg_wr_data <= {9'd0, ld};
        @(posedge i_clk);
        half_res       = ld;
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic t_cmd random_cmd(input t_action act);
        t_cmd c;
        c.action = act;
        c.index  = 12'($urandom_range(TILE_TEXELS - 1));
        c.value  = 8'($urandom_range(255));
        // texel bytes stay on multiples of eight so every shade read hits a loaded entry
        if (act == ACT_TEXEL) c.value[2:0] = 3'd0;
        c.row    = 10'($urandom_range(1023));
        c.start  = 10'($urandom_range(1023));
        c.count  = 11'($urandom_range(1, 64));
        c.u      = $urandom;
        c.v      = $urandom;
        c.du     = $urandom;
        c.dv     = $urandom;
        c.flat   = ($urandom_range(9) == 0);
        return c;
    endfunction

    function automatic t_cmd noise_cmd();
        t_cmd c;
        c = random_cmd($urandom_range(1) ? ACT_SHADE : ACT_TEXEL);
        // keep most shade loads in range so the table keeps changing
        if (c.action == ACT_SHADE && $urandom_range(3) != 0)
            c.index = 12'($urandom_range(255));
        return c;
    endfunction

    // build a span whose texel reads stay on loaded texels for its whole length
    function automatic t_cmd span_with_count(input logic [10:0] count);
        t_cmd c;
        int   n;
        int   u_lo;
        int   v_lo;
        c = random_cmd(ACT_SPAN);
        c.count = count;
        n = (count > MAX_SPAN) ? int'(MAX_SPAN) : int'(count);
        if ($urandom_range(1)) begin
            // whole-texel steps keep every read on the 16-texel lattice
            c.u  = $urandom & 32'hFFF0_FFFF;
            c.v  = $urandom & 32'hFFF0_FFFF;
            c.du = $urandom & 32'hFFF0_0000;
            c.dv = $urandom & 32'hFFF0_0000;
        end else begin
            // fractional steps walk inside the 2x2 block at the tile origin
            u_lo = int'($urandom_range(131071));
            v_lo = int'($urandom_range(131071));
            c.u  = ($urandom & 32'hFFC0_0000) | 32'(u_lo);
            c.v  = ($urandom & 32'hFFC0_0000) | 32'(v_lo);
            if (n > 1) begin
                c.du = (int'($urandom_range(131071)) - u_lo) / (n - 1);
                c.dv = (int'($urandom_range(131071)) - v_lo) / (n - 1);
            end
        end
        return c;
    endfunction

    function automatic t_cmd span_cmd();
        int          r;
        logic [10:0] count;
        r = $urandom_range(99);
        if (r < 4)       count = '0;
        else if (r < 7)  count = 11'($urandom_range(1024, 2047));
        else if (r < 65) count = 11'($urandom_range(1, 64));
        else             count = 11'($urandom_range(65, 300));
        return span_with_count(count);
    endfunction

    task automatic run_span_sequence();
        int r;
        send_item(span_cmd());
        while (pixels_left != 0) begin
            r = $urandom_range(99);
            if (r < 4) break;
            if (r < 14) send_item(noise_cmd());
            send_item(random_cmd(ACT_CONT));
        end
        if ($urandom_range(99) < 15) send_item(random_cmd(ACT_CONT));
    endtask

    task automatic run_traffic(input int budget, input bit pause_midway);
        int first;
        first = items_sent;
        while (items_sent - first < budget) begin
            if ($urandom_range(99) < 20) send_item(noise_cmd());
            else run_span_sequence();
            if (pause_midway && items_sent - first >= budget / 2) begin
                hold_until_idle();
                pause_midway = 1'b0;
            end
        end
    endtask

    // load the lattice texels, the 2x2 block at the origin, the texels that
    // the window test reads, and every shade entry a texel byte can select
    task automatic preload_tables();
        t_cmd c;
        int   extra [7] = '{1, 64, 65, 63, 127, 190, 4095};
        for (int i = 0; i < 16; i++) begin
            c = random_cmd(ACT_TEXEL);
            c.index = 12'((i / 4) * 1024 + (i % 4) * 16);
            send_item(c);
        end
        for (int k = 0; k < 7; k++) begin
            c = random_cmd(ACT_TEXEL);
            c.index = 12'(extra[k]);
            send_item(c);
        end
        for (int i = 0; i < SHADE_ENTRIES; i += 8) begin
            c = random_cmd(ACT_SHADE);
            c.index = 12'(i);
            send_item(c);
        end
        hold_until_idle();
    endtask

    task automatic test_shade_index_range();
        t_cmd c;
        c = random_cmd(ACT_TEXEL);
        c.index = '0;
        c.value = 8'h5A;
        send_item(c);
        c = random_cmd(ACT_SHADE);
        c.index = 12'h05A;
        c.value = 8'h11;
        send_item(c);
        // out-of-range shade loads must leave the table alone
        c.index = 12'h15A;
        c.value = 8'hEE;
        send_item(c);
        c.index = 12'hFFF;
        c.value = 8'hFF;
        send_item(c);
        c = random_cmd(ACT_SPAN);
        c.count = 11'd3;
        c.flat  = 1'b1;
        send_item(c);
        hold_until_idle();
    endtask

    task automatic test_count_edges();
        t_cmd c;
        c = span_with_count(11'd0);
        send_item(c);
        send_item(random_cmd(ACT_CONT));
        c = span_with_count(11'd1);
        send_item(c);
        c = span_with_count(11'(BURST_PIXELS_DEF));
        send_item(c);
        send_item(random_cmd(ACT_CONT));
        // oversized count clamps to a full-length span
        c = span_with_count(11'd2047);
        c.flat = 1'b0;
        send_item(c);
        while (pixels_left != 0) send_item(random_cmd(ACT_CONT));
        send_item(random_cmd(ACT_CONT));
        hold_until_idle();
    endtask

    task automatic test_window_extremes();
        t_cmd c;
        set_window(10'd1023, 10'd1023, 1'b1);
        c = random_cmd(ACT_SPAN);
        c.row   = 10'd1023;
        c.start = 10'd1022;
        c.count = 11'd4;
        c.u     = 32'h7FFF_FFFF;
        c.v     = 32'h8000_0000;
        c.du    = 32'h8000_0000;
        c.dv    = 32'h7FFF_FFFF;
        c.flat  = 1'b0;
        send_item(c);
        c = random_cmd(ACT_SPAN);
        c.row   = '0;
        c.start = '0;
        c.count = 11'd3;
        c.u     = 32'h0000_0000;
        c.v     = 32'h0000_0000;
        c.du    = 32'hFFFF_0000;
        c.dv    = 32'h0001_0000;
        c.flat  = 1'b0;
        send_item(c);
        hold_until_idle();
        set_window(10'd0, 10'd0, 1'b0);
        c = random_cmd(ACT_SPAN);
        c.row   = 10'd1023;
        c.start = 10'd1023;
        c.count = 11'd2;
        c.u     = 32'hFFFF_FFFF;
        c.v     = 32'hFFFF_FFFF;
        c.du    = 32'h0000_0000;
        c.dv    = 32'h0000_0000;
        c.flat  = 1'b0;
        send_item(c);
        hold_until_idle();
    endtask

    task automatic test_random_traffic();
        int sender_pcts [4] = '{0, 50, 0, 27};
        int stall_pcts  [4] = '{0, 0, 50, 27};
        for (int p = 0; p < 4; p++) begin
            hold_until_idle();
            case (p)
                0:       set_window(10'd0, 10'd0, 1'b0);
                1:       set_window(10'd1023, 10'd1023, 1'b1);
                default: set_window(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                    1'($urandom_range(1)));
            endcase
            sender_idle_pct = sender_pcts[p];
            stall_pct       = stall_pcts[p];
            run_traffic(PHASE_ITEMS, p == 2);
        end
        hold_until_idle();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_pixels.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected pixel: col %0d row %0d color %0d ",
                             o_screen_column, o_screen_row, o_pixel_color,
                             "pair %0b last %0b done %0b",
                             o_pixel_pair, o_burst_last, o_span_done);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_screen_column !== want.column || o_screen_row !== want.row ||
                    o_pixel_color !== want.color || o_pixel_pair !== want.pair ||
                    o_burst_last !== want.last || o_span_done !== want.done) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("pixel mismatch: exp col %0d row %0d color %0d ",
                                 want.column, want.row, want.color,
                                 "pair %0b last %0b done %0b, ",
                                 want.pair, want.last, want.done,
                                 "got col %0d row %0d color %0d ",
                                 o_screen_column, o_screen_row, o_pixel_color,
                                 "pair %0b last %0b done %0b",
                                 o_pixel_pair, o_burst_last, o_span_done);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        preload_tables();
        test_shade_index_range();
        test_count_edges();
        test_window_extremes();
        test_random_traffic();
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/asm_pkg.sv
design/asm_fifo.sv
design/asm_front.sv
design/asm_back.sv
design/affine_span_texture_mapper_top.sv
sim/affine_span_texture_mapper_top_tb.sv
